/* hdl/bepc_pkg.sv */
// ----------------------------------------------------------------------------
// bepc_pkg
// Shared types and constants for the 3x3 binary erosion pixel counter.
// ----------------------------------------------------------------------------
package bepc_pkg;

  // Field widths
  localparam int PIX_W   = 4;
  localparam int SIDE_W  = 8;
  localparam int COUNT_W = 15;

  // Saturation point of the survivor count
  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

  // All nine window bits set
  localparam logic [8:0] FULL_WINDOW = 9'h1FF;

  // One column entry of the line store: row two above and row above
  typedef struct packed {
    logic top;
    logic mid;
  } col_bits_t;

endpackage

/* hdl/binary_erosion_pixel_count_core.sv */
// ----------------------------------------------------------------------------
// binary_erosion_pixel_count_core
// 3x3 binary erosion over a square raster image with a per-frame survivor count.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order (nonzero is land) and reports, one
// transfer after the last pixel of each frame, how many pixels have a full 3x3
// land neighborhood. A pixel is taken every cycle unless the input stalls: the
// position counters issue the line store read as the pixel is accepted, and the
// window update and line store write-back follow in stage 1, so the
// single-port-pair line memory sets the rate at one pixel per cycle. The count
// is formed in stage 1 and waits in an output register; input stalls only when a
// second count is ready while the first is still untaken. Writing cfg_wdata
// starts a new frame; side 0 acts as 1 and sides above MAX_SIDE act as MAX_SIDE.
// The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module binary_erosion_pixel_count_core #(
  parameter int MAX_SIDE = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bepc_pkg::SIDE_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bepc_pkg::PIX_W-1:0]   in_pixel_digit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bepc_pkg::COUNT_W-1:0] out_survivor_count
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int PW = $clog2(MAX_SIDE + 1);
  localparam int SW = (PW > bepc_pkg::SIDE_W) ? PW : bepc_pkg::SIDE_W;
  localparam logic [bepc_pkg::SIDE_W-1:0] SIDE_RST =
    (MAX_SIDE > 255) ? 8'd255 : bepc_pkg::SIDE_W'(MAX_SIDE);
  localparam logic [SW-1:0] MAX_SIDE_S = SW'(MAX_SIDE);

  // Registers
  logic [bepc_pkg::SIDE_W-1:0]  side_r;
  logic [AW-1:0]                col_r, col_nxt;
  logic [AW-1:0]                row_r, row_nxt;
  logic [bepc_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic [8:0]                   win_r, win_nxt;
  logic                         s1_valid_r;
  logic                         s1_land_r;
  logic [AW-1:0]                s1_col_r;
  logic                         s1_test_r;
  logic                         s1_last_r;
  logic                         out_valid_r;
  logic [bepc_pkg::COUNT_W-1:0] out_count_r;

  // Stage 0 signals
  logic [SW-1:0]  side_act;
  logic [AW-1:0]  c0, r0;
  logic           last0, test0, wrap0;
  logic           in_fire;

  // Stage 1 signals
  logic                         s1_stall, s1_fire, hit;
  logic [bepc_pkg::COUNT_W-1:0] total_inc;
  bepc_pkg::col_bits_t          rd_col, wr_col;

  // Active side after clamping
  always_comb begin
    side_act = SW'(side_r);
    if (side_r == '0) begin
      side_act = SW'(1);
    end else if (SW'(side_r) > MAX_SIDE_S) begin
      side_act = MAX_SIDE_S;
    end
  end

  // Stage 0: raster position of the incoming pixel
  always_comb begin
    c0      = (SW'(col_r) >= side_act) ? '0 : col_r;
    r0      = (SW'(row_r) >= side_act) ? '0 : row_r;
    wrap0   = (SW'(c0) + SW'(1)) == side_act;
    last0   = wrap0 && ((SW'(r0) + SW'(1)) == side_act);
    test0   = (r0 >= AW'(2)) && (c0 >= AW'(2));
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (last0) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (wrap0) begin
        col_nxt = '0;
        row_nxt = r0 + AW'(1);
      end else begin
        col_nxt = c0 + AW'(1);
        row_nxt = r0;
      end
    end
  end

  // Handshake: stall only when a new count meets an untaken one
  assign s1_stall = s1_valid_r && s1_last_r && out_valid_r && !out_ready;
  assign s1_fire  = s1_valid_r && !s1_stall;
  assign in_ready = !s1_stall;
  assign in_fire  = in_valid && in_ready;

  // Line store: bit top holds the row two above, bit mid the row above
  bepc_line_store #(
    .DEPTH (MAX_SIDE),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (c0),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (wr_col),
    .rd_data (rd_col)
  );

  // Stage 1: window shift, test and count
  always_comb begin
    wr_col.top = rd_col.mid;
    wr_col.mid = s1_land_r;
    win_nxt    = {win_r[5:0], rd_col.top, rd_col.mid, s1_land_r};
    hit        = s1_test_r && (win_nxt == bepc_pkg::FULL_WINDOW);
    total_inc  = total_r;
    if (hit && (total_r != bepc_pkg::COUNT_MAX)) begin
      total_inc = total_r + 1'b1;
    end
    total_nxt = total_r;
    if (cfg_we) begin
      total_nxt = '0;
    end else if (s1_fire) begin
      total_nxt = s1_last_r ? '0 : total_inc;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SIDE_RST;
      col_r       <= '0;
      row_r       <= '0;
      total_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        side_r <= cfg_wdata;
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      total_r <= total_nxt;
      if (in_ready) begin
        s1_valid_r <= in_fire;
      end
      if (s1_fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_land_r <= (in_pixel_digit != '0);
      s1_col_r  <= c0;
      s1_test_r <= test0;
      s1_last_r <= last0;
    end
    if (s1_fire) begin
      win_r <= win_nxt;
    end
    if (s1_fire && s1_last_r) begin
      out_count_r <= total_inc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_survivor_count = out_count_r;

  // Input backpressure only while a finished count is blocked
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked count");

  // A configuration write restarts the frame
  a_cfg_clear : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (col_r == '0 && row_r == '0 && total_r == '0))
    else $error("frame state not cleared by configuration write");

  // Raster position stays inside the active image
  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(col_r) < side_act) && (SW'(row_r) < side_act))
    else $error("raster position out of range");

  // A count leaves stage 1 only on the last pixel of a frame
  a_out_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_fire && s1_last_r))
    else $error("count presented without a frame end");

endmodule

/* hdl/bepc_line_store.sv */
// ----------------------------------------------------------------------------
// bepc_line_store
// Two line stores packed into one synchronous memory, one read and one write
// port, registered read, with write-to-read forwarding on a collision.
// ----------------------------------------------------------------------------
module bepc_line_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  bepc_pkg::col_bits_t wr_data,
  output bepc_pkg::col_bits_t rd_data
);

  bepc_pkg::col_bits_t mem [DEPTH];
  bepc_pkg::col_bits_t mem_q_r;
  bepc_pkg::col_bits_t fwd_data_r;
  logic                fwd_r;

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port; holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Capture write data when it lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

/* tb/sv/tb_binary_erosion_pixel_count_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_erosion_pixel_count_core
// Self-checking bench for the 3x3 erosion survivor counter.
// ----------------------------------------------------------------------------
// Streams square frames of random and hand-picked pixels through the core. A
// bit-level predictor (line stores, window, raster position) queues the count
// for each completed frame, and every count transfer is checked against the
// oldest entry in that queue. Covers the reset side, tiny and oversize sides,
// the frame restart on a side write, random gaps on both channels and a long
// output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_binary_erosion_pixel_count_core;

  localparam int MAX_SIDE      = 128;
  localparam int RANDOM_PIXELS = 950;
  localparam int MIN_FRAMES    = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  // DUT ports
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [bepc_pkg::SIDE_W-1:0]  cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [bepc_pkg::PIX_W-1:0]   in_pixel_digit = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [bepc_pkg::COUNT_W-1:0] out_survivor_count;

  // Predictor state
  logic                         row_above [MAX_SIDE];
  logic                         row_two_above [MAX_SIDE];
  logic [8:0]                   win_bits;
  int unsigned                  col_idx;
  int unsigned                  row_idx;
  logic [bepc_pkg::COUNT_W-1:0] frame_survivors;
  logic [bepc_pkg::SIDE_W-1:0]  side_setting;

  // Expected counts, oldest first
  logic [bepc_pkg::COUNT_W-1:0] expected_counts [$];
  logic [bepc_pkg::COUNT_W-1:0] want_count;

  int  error_count = 0;
  int  pixels_sent = 0;
  int  frames_predicted = 0;
  int  cycle_count = 0;
  bit  tx_stalls_on = 1'b0;

  // Receiver control
  bit  rx_stalls_on = 1'b0;
  int  hold_req_id = 0;
  int  hold_taken_id = 0;
  int  hold_left = 0;
  int  rx_gap_left = 0;

  binary_erosion_pixel_count_core #(
    .MAX_SIDE(MAX_SIDE)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_digit    (in_pixel_digit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_survivor_count(out_survivor_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Side 0 behaves as 1, anything above MAX_SIDE as MAX_SIDE
  function automatic int unsigned active_side();
    int unsigned s;
    s = 32'(side_setting);
    if (s == 0) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  // Advance the erosion model by one accepted pixel
  task automatic predict_pixel(input logic [bepc_pkg::PIX_W-1:0] digit);
    int unsigned side;
    int unsigned c;
    int unsigned r;
    logic        land;
    logic        up1;
    logic        up2;
    side = active_side();
    c = (col_idx >= side) ? 0 : col_idx;
    r = (row_idx >= side) ? 0 : row_idx;
    land = (digit != '0);
    up2 = row_two_above[c];
    up1 = row_above[c];
    win_bits = {win_bits[5:0], up2, up1, land};
    row_two_above[c] = up1;
    row_above[c] = land;
    // interior centers only
    if (r >= 2 && c >= 2 && win_bits == bepc_pkg::FULL_WINDOW &&
        frame_survivors != bepc_pkg::COUNT_MAX)
      frame_survivors = frame_survivors + 1'b1;
    if (c + 1 == side && r + 1 == side) begin
      expected_counts.push_back(frame_survivors);
      frames_predicted++;
      col_idx = 0;
      row_idx = 0;
      frame_survivors = '0;
    end else begin
      c++;
      if (c >= side) begin
        c = 0;
        r++;
      end
      col_idx = c;
      row_idx = r;
    end
  endtask

  // One pixel transfer; valid stays high afterwards unless a gap follows
  task automatic send_pixel(input logic [bepc_pkg::PIX_W-1:0] digit);
    int gap;
    gap = (tx_stalls_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_digit <= digit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(digit);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int unsigned count, input int land_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < land_pct)
        send_pixel(bepc_pkg::PIX_W'($urandom_range(1, 9)));
      else send_pixel('0);
    end
  endtask

  // Sender goes quiet until every count is back and the pipe is empty
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Side write, also restarts the frame
  task automatic write_side(input logic [bepc_pkg::SIDE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_setting = value;
    col_idx = 0;
    row_idx = 0;
    frame_survivors = '0;
  endtask

  // Output channel: random stalls plus a requested long hold-off
  always @(posedge clk) begin
    if (hold_req_id != hold_taken_id) begin
      hold_taken_id <= hold_req_id;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left <= rx_gap_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
      rx_gap_left <= gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Count checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected count transfer: expected none, got %0d",
                 $time, out_survivor_count);
        error_count++;
      end else begin
        want_count = expected_counts.pop_front();
        if (out_survivor_count !== want_count) begin
          $display("%0t: survivor_count mismatch: expected %0d, got %0d",
                   $time, want_count, out_survivor_count);
          error_count++;
        end
      end
    end
  end

  // Opening rows at the reset side, mostly land; the next side write cuts the frame
  task automatic test_reset_side_frame();
    tx_stalls_on = 1'b0;
    rx_stalls_on <= 1'b1;
    send_pixels(3 * MAX_SIDE, 97);
    wait_for_results();
  endtask

  // Tiny sides and a restart in the middle of a frame
  task automatic test_tiny_and_restart();
    tx_stalls_on = 1'b1;
    // side 0 acts as 1
    write_side('0);
    send_pixel(4'd9);
    wait_for_results();
    write_side(8'd1);
    send_pixel(4'd8);
    wait_for_results();
    write_side(8'd2);
    send_pixel(4'd8);
    send_pixel(4'd9);
    send_pixel(4'd1);
    send_pixel(4'd5);
    wait_for_results();
    // partial frame, then a rewrite must restart counting
    write_side(8'd3);
    send_pixels(4, 100);
    wait_for_results();
    write_side(8'd3);
    for (int d = 1; d <= 9; d++) send_pixel(bepc_pkg::PIX_W'(d));
    wait_for_results();
  endtask

  // Random sides, fill densities and idling, with some abandoned frames
  task automatic test_random_frames();
    int          start_pixels;
    int          start_frames;
    int          pick;
    int unsigned side;
    int          land_pct;
    start_pixels = pixels_sent;
    start_frames = frames_predicted;
    while (pixels_sent - start_pixels < RANDOM_PIXELS ||
           frames_predicted - start_frames < MIN_FRAMES) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) write_side('0);
      else if (pick < 10) write_side(8'd1);
      else if (pick < 15) write_side(8'd2);
      else if (pick < 75) write_side(bepc_pkg::SIDE_W'($urandom_range(3, 8)));
      else if (pick < 95) write_side(bepc_pkg::SIDE_W'($urandom_range(9, 16)));
      else write_side(bepc_pkg::SIDE_W'($urandom_range(17, 24)));
      side = active_side();
      tx_stalls_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on <= ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: land_pct = 50;
          1: land_pct = 85;
          2: land_pct = 97;
          default: land_pct = 100;
        endcase
        send_pixels(side * side, land_pct);
      end
      // abandoned frame, cut off by the next side write
      if ($urandom_range(0, 7) == 0)
        send_pixels($urandom_range(1, side * side), 90);
      wait_for_results();
    end
  endtask

  // Long output hold-off while frames keep coming
  task automatic test_output_backpressure();
    tx_stalls_on = 1'b0;
    rx_stalls_on <= 1'b0;
    write_side(8'd3);
    hold_req_id <= hold_req_id + 1;
    repeat (16) send_pixels(9, 92);
    wait_for_results();
  endtask

  // Side above the limit clamps to MAX_SIDE; opening rows only
  task automatic test_oversize_side();
    tx_stalls_on = 1'b0;
    rx_stalls_on <= 1'b1;
    write_side(8'hFF);
    send_pixels(3 * MAX_SIDE, 93);
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      row_above[i] = 1'b0;
      row_two_above[i] = 1'b0;
    end
    win_bits = '0;
    col_idx = 0;
    row_idx = 0;
    frame_survivors = '0;
    side_setting = bepc_pkg::SIDE_W'(MAX_SIDE);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_side_frame();
    test_tiny_and_restart();
    test_random_frames();
    test_output_backpressure();
    test_oversize_side();

    if (expected_counts.size() != 0) begin
      $display("%0t: %0d expected counts never arrived", $time, expected_counts.size());
      error_count++;
    end
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hdl/bepc_pkg.sv
hdl/bepc_line_store.sv
hdl/binary_erosion_pixel_count_core.sv
tb/sv/tb_binary_erosion_pixel_count_core.sv
